/* sv/u8d_pkg.sv */
package u8d_pkg;

    localparam int unsigned MAX_RES    = 4;
    localparam int unsigned HELD_DEPTH = 3;
    localparam int unsigned CP_W       = 21;

    localparam logic [CP_W-1:0] SUBST_CP = 21'h00FFFD;

    typedef logic [2:0] t_len;
    typedef logic [2:0] t_num;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            repl;
    } t_res;

    typedef struct packed {
        logic valid;
        logic last;
        logic free;
    } t_q_status;

    // sequence length from a lead byte, zero for a bad lead
    function automatic t_len lead_len(input logic [7:0] b);
        if (!b[7]) begin
            return 3'd1;
        end else if (b[7:5] == 3'b110) begin
            return 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            return 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            return 3'd4;
        end else begin
            return 3'd0;
        end
    endfunction

    // w holds up to four bytes, lead in the low byte
    function automatic logic [CP_W-1:0] combine(input logic [31:0] w, input t_len len);
        case (len)
            3'd2: begin
                return {10'b0, w[4:0], w[13:8]};
            end
            3'd3: begin
                return {5'b0, w[3:0], w[13:8], w[21:16]};
            end
            3'd4: begin
                return {w[2:0], w[13:8], w[21:16], w[29:24]};
            end
            default: begin
                return {14'b0, w[6:0]};
            end
        endcase
    endfunction

endpackage

/* sv/utf8_byte_stream_decoder.sv */
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_text_byte, i_end_of_text
// result    out        o_valid / i_ready  o_code_point, o_replaced, o_run_last
//
// one byte is accepted per cycle while the result queue is free; its results follow in the next cycle
// a byte with end_of_text gives up to four results, one per cycle while i_ready is high, and
// input is held off until the last of them is taken
// synchronous active-low reset clears the held count and the result queue
// a stalled result holds its value; input waits behind every result and may enter as the last is taken
module utf8_byte_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_code_point,
    output logic        o_replaced,
    output logic        o_run_last
);
    import u8d_pkg::*;

    logic [7:0] r_held [HELD_DEPTH];
    logic [1:0] r_held_count;
    logic [1:0] n_held_count;

    logic [7:0]  bytes [MAX_RES];
    logic [55:0] ext;
    logic [31:0] win;
    t_len        m;
    t_len        lead;
    t_len        l;
    t_len        pos;
    t_num        num;
    t_res        res [MAX_RES];
    logic        hold;
    logic        accept;
    logic        pop;
    t_res        head;
    t_q_status   qs;

    assign accept = i_valid && o_ready;
    assign pop    = qs.valid && i_ready;

    always_comb begin
        for (int k = 0; k < HELD_DEPTH; k++) begin
            if (2'(k) < r_held_count) begin
                bytes[k] = r_held[k];
            end else if (2'(k) == r_held_count) begin
                bytes[k] = i_text_byte;
            end else begin
                bytes[k] = '0;
            end
        end
        bytes[MAX_RES-1] = (r_held_count == 2'd3) ? i_text_byte : '0;
        ext  = {24'b0, bytes[3], bytes[2], bytes[1], bytes[0]};
        m    = {1'b0, r_held_count} + 3'd1;
        lead = lead_len(bytes[0]);
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = '0;
        end
        num          = '0;
        hold         = 1'b0;
        n_held_count = r_held_count;
        pos          = '0;
        win          = '0;
        l            = '0;
        if (i_end_of_text) begin
            // parse the whole buffer, bad or cut leads become substitutes
            for (int s = 0; s < MAX_RES; s++) begin
                if (pos < m) begin
                    win = ext[{pos[1:0], 3'b000} +: 32];
                    l   = lead_len(win[7:0]);
                    if ((l != 3'd0) && ((pos + l) <= m)) begin
                        res[s] = '{cp: combine(win, l), repl: 1'b0};
                        pos    = pos + l;
                    end else begin
                        res[s] = '{cp: SUBST_CP, repl: 1'b1};
                        pos    = pos + 3'd1;
                    end
                    num = num + 3'd1;
                end
            end
            n_held_count = '0;
        end else if (lead == 3'd0) begin
            res[0]       = '{cp: SUBST_CP, repl: 1'b1};
            num          = 3'd1;
            n_held_count = '0;
        end else if (lead == m) begin
            res[0]       = '{cp: combine(ext[31:0], lead), repl: 1'b0};
            num          = 3'd1;
            n_held_count = '0;
        end else begin
            hold         = 1'b1;
            n_held_count = m[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HELD_DEPTH; k++) begin
            if (accept && hold && (2'(k) == r_held_count)) begin
                r_held[k] <= i_text_byte;
            end
        end
        if (!i_rst_n) begin
            r_held_count <= '0;
        end else if (accept) begin
            r_held_count <= n_held_count;
        end
    end

    u8d_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_res    (res),
        .i_num    (num),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (qs)
    );

    assign o_ready      = i_rst_n && qs.free;
    assign o_valid      = qs.valid;
    assign o_code_point = head.cp;
    assign o_replaced   = head.repl;
    assign o_run_last   = qs.last;

endmodule

/* sv/u8d_outq.sv */
module u8d_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  u8d_pkg::t_res        i_res [u8d_pkg::MAX_RES],
    input  u8d_pkg::t_num        i_num,
    input  logic                 i_pop,
    output u8d_pkg::t_res        o_head,
    output u8d_pkg::t_q_status   o_status
);
    import u8d_pkg::*;

    t_res r_ent [MAX_RES];
    t_res n_ent [MAX_RES];
    t_num r_cnt;
    t_num n_cnt;

    always_comb begin
        n_ent = r_ent;
        n_cnt = r_cnt;
        if (i_load) begin
            n_ent = i_res;
            n_cnt = i_num;
        end else if (i_pop) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                n_ent[k] = r_ent[k+1];
            end
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_head          = r_ent[0];
    assign o_status.valid  = (r_cnt != 3'd0);
    assign o_status.last   = (r_cnt == 3'd1);
    assign o_status.free   = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_pop);

endmodule

/* sv/u8d_checker.sv */
module u8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_end_of_text,
    input logic        o_valid,
    input logic        i_ready,
    input logic [20:0] o_code_point,
    input logic        o_replaced,
    input logic        o_run_last
);
    import u8d_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_point) && $stable(o_replaced)
            && $stable(o_run_last))
        else $error("stalled result changed");

    a_subst_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_replaced |-> o_code_point == SUBST_CP)
        else $error("replaced result is not the substitute");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_end_of_text |=> o_valid)
        else $error("end of text gave no result");

    a_no_request_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_run_last |-> !o_ready)
        else $error("input taken while a run is still draining");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_u8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_end_of_text (i_end_of_text),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_code_point  (o_code_point),
    .o_replaced    (o_replaced),
    .o_run_last    (o_run_last)
);

/* sim/utf8_byte_stream_decoder_test.sv */
module utf8_byte_stream_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LONG_HOLD = 80;

    typedef struct packed {
        logic [20:0] cp;
        logic        repl;
        logic        last;
    } t_decoded;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [20:0] o_code_point;
    logic        o_replaced;
    logic        o_run_last;

    t_decoded    pending_code_points[$];
    logic [7:0]  held_text[0:2];
    int unsigned held_num = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned mismatch_count = 0;
    bit          hold_off_pending = 1'b0;

    utf8_byte_stream_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_point  (o_code_point),
        .o_replaced    (o_replaced),
        .o_run_last    (o_run_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned seq_length(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    function automatic logic [20:0] assemble(input logic [3:0][7:0] window,
                                             input int unsigned first,
                                             input int unsigned len);
        logic [20:0] value;
        int unsigned k;
        case (len)
            2: value = 21'(window[first][4:0]);
            3: value = 21'(window[first][3:0]);
            4: value = 21'(window[first][2:0]);
            default: value = 21'(window[first][6:0]);
        endcase
        for (k = 1; k < len; k++) begin
            value = {value[14:0], window[first + k][5:0]};
        end
        return value;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [3:0][7:0] window;
        int unsigned fill;
        int unsigned pos;
        int unsigned len;
        t_decoded found[$];
        t_decoded r;
        window = '0;
        for (pos = 0; pos < held_num; pos++) begin
            window[pos] = held_text[pos];
        end
        window[held_num] = b;
        fill = held_num + 1;
        len = seq_length(window[0]);
        r.last = 1'b0;
        if (eot) begin
            pos = 0;
            while (pos < fill) begin
                len = seq_length(window[pos]);
                if (len != 0 && pos + len <= fill) begin
                    r.cp = assemble(window, pos, len);
                    r.repl = 1'b0;
                    pos += len;
                end else begin
                    r.cp = u8d_pkg::SUBST_CP;
                    r.repl = 1'b1;
                    pos++;
                end
                found.push_back(r);
            end
            held_num = 0;
        end else if (len == 0) begin
            r.cp = u8d_pkg::SUBST_CP;
            r.repl = 1'b1;
            found.push_back(r);
            held_num = 0;
        end else if (len == fill) begin
            r.cp = assemble(window, 0, len);
            r.repl = 1'b0;
            found.push_back(r);
            held_num = 0;
        end else begin
            for (pos = 0; pos < fill; pos++) begin
                held_text[pos] = window[pos];
            end
            held_num = fill;
        end
        foreach (found[k]) begin
            found[k].last = (k == found.size() - 1);
            pending_code_points.push_back(found[k]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_text_byte <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
        decode_byte(b, eot);
    endtask

    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic send_paced(input logic [7:0] b, input logic eot);
        send_byte(b, eot);
        if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (pending_code_points.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_complete_sequences();
        send_paced(8'h00, 1'b0);
        send_paced(8'h7f, 1'b0);
        send_paced(8'hc0, 1'b0);
        send_paced(8'h80, 1'b0);
        send_paced(8'hdf, 1'b0);
        send_paced(8'hbf, 1'b0);
        send_paced(8'hef, 1'b0);
        send_paced(8'hbf, 1'b0);
        send_paced(8'hbf, 1'b0);
        send_paced(8'hf7, 1'b0);
        send_paced(8'hbf, 1'b0);
        send_paced(8'hbf, 1'b0);
        send_paced(8'hbf, 1'b0);
    endtask

    task automatic test_bad_leads();
        send_paced(8'h80, 1'b0);
        send_paced(8'hf8, 1'b0);
        send_paced(8'hff, 1'b0);
    endtask

    task automatic test_end_of_text();
        send_paced(8'h41, 1'b1);
        // held bytes decoded together with an end-of-text byte
        send_paced(8'he2, 1'b0);
        send_paced(8'h82, 1'b0);
        send_paced(8'h41, 1'b1);
        send_paced(8'hf0, 1'b0);
        send_paced(8'h9f, 1'b0);
        send_paced(8'h98, 1'b0);
        send_paced(8'h80, 1'b1);
        send_paced(8'hc3, 1'b0);
        send_paced(8'hff, 1'b1);
    endtask

    task automatic test_random_text(input int unsigned count);
        int unsigned start;
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        int unsigned k;
        logic [7:0] r;
        logic [7:0] b;
        logic eot_here;
        start = items_sent;
        while (items_sent - start < count) begin
            kind = $urandom_range(0, 99);
            len = $urandom_range(1, 4);
            if (kind < 12) begin
                send_paced(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end else begin
                cut = (kind < 24) ? $urandom_range(1, len) : len;
                eot_here = ($urandom_range(0, 9) == 0);
                for (k = 0; k < cut; k++) begin
                    r = 8'($urandom);
                    if (k == 0) begin
                        case (len)
                            1: b = {1'b0, r[6:0]};
                            2: b = {3'b110, r[4:0]};
                            3: b = {4'b1110, r[3:0]};
                            default: b = {5'b11110, r[2:0]};
                        endcase
                    end else if ($urandom_range(0, 7) == 0) begin
                        b = r;
                    end else begin
                        b = {2'b10, r[5:0]};
                    end
                    send_paced(b, eot_here && (k == cut - 1));
                end
            end
        end
    endtask

    task automatic test_full_stall();
        hold_off_pending = 1'b1;
        repeat (30) begin
            send_byte(8'($urandom_range(0, 127)), 1'b0);
        end
        idle_cycles(1);
        while (hold_off_pending) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            test_random_text(8);
            wait_drained();
            idle_cycles($urandom_range(1, 10));
        end
    endtask

    initial begin : result_sink
        int unsigned mode;
        int unsigned stretch;
        int unsigned held;
        int unsigned phase;
        phase = 0;
        forever begin
            mode = $urandom_range(0, 2);
            stretch = $urandom_range(5, 40);
            repeat (stretch) begin
                @(negedge i_clk);
                if (hold_off_pending) begin
                    i_ready <= 1'b0;
                    for (held = 1; held < LONG_HOLD; held++) begin
                        @(negedge i_clk);
                    end
                    hold_off_pending = 1'b0;
                end else begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= ($urandom_range(0, 3) != 0);
                        default: i_ready <= (phase % 3 != 2);
                    endcase
                    phase++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_code_points
        t_decoded want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_code_points.size() == 0) begin
                $display("%0t: unexpected result code_point %h replaced %b run_last %b",
                         $time, o_code_point, o_replaced, o_run_last);
                mismatch_count++;
            end else begin
                want = pending_code_points.pop_front();
                if (o_code_point !== want.cp) begin
                    $display("%0t: code_point expected %h actual %h",
                             $time, want.cp, o_code_point);
                    mismatch_count++;
                end
                if (o_replaced !== want.repl) begin
                    $display("%0t: replaced expected %b actual %b",
                             $time, want.repl, o_replaced);
                    mismatch_count++;
                end
                if (o_run_last !== want.last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, want.last, o_run_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_complete_sequences();
        test_bad_leads();
        test_end_of_text();
        test_random_text(190);
        test_full_stall();
        test_drain_pause();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (pending_code_points.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, pending_code_points.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
